/* hdl/kinl_pkg.sv */
package kinl_pkg;

	typedef enum logic [2:0] {
		KIND_IDENT,
		KIND_KEYWORD,
		KIND_NUMBER,
		KIND_SYMBOL,
		KIND_END
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  length;
		logic [7:0]  sym;
		logic        too_long;
		logic        last;
	} token_t;

	localparam int          NUM_KW        = 3;
	localparam logic [2:0]  ALL_CANDIDATES = 3'b111;

	// keyword text, bit0 int, bit1 return, bit2 print
	localparam logic [7:0] KW_TEXT [NUM_KW][6] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"},
		'{"p", "r", "i", "n", "t", 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd6, 3'd5};

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word_start(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

endpackage

/* hdl/keyword_identifier_number_lexer_top.sv */
// Path: a request is held in the input register, then its tokens are written into the
//   4-entry output queue, which drains one per cycle while m_tready is high.
// Throughput: one byte per cycle while the queue has room for two tokens; a byte that
//   closes a word and is itself a symbol gives two tokens.
// Reset: arst_n clears the lexer state (between tokens, all keyword candidates
//   open) and empties the output queue at once.
module keyword_identifier_number_lexer_top #(
	parameter int MAX_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tuser,   // [0] end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [15:0] m_tdata,  // [5:0] token_length, [13:6] symbol_byte,
	                              // [14] too_long, [15] zero
	output logic [2:0] m_tuser,   // [2:0] token_kind
	output logic       m_tlast    // last_of_run
);
	import kinl_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN);
	localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_LEN - 1);

	logic             v_s1;
	logic [7:0]       byte_s1;
	logic             eoi_s1;

	mode_t            mode_q;
	logic [LEN_W-1:0] len_q;
	logic [2:0]       cand_q;
	logic             ovf_q;

	token_t           fifo_q [4];
	logic [1:0]       wr_ptr_q;
	logic [1:0]       rd_ptr_q;
	logic [2:0]       count_q;

	logic             proc;
	logic             pop;
	mode_t            mode_d;
	logic [LEN_W-1:0] len_d;
	logic [2:0]       cand_d;
	logic             ovf_d;
	token_t           res0;
	token_t           res1;
	logic [1:0]       n_res;

	logic [2:0]       cand_take;
	logic [LEN_W-1:0] len_take;
	logic             ovf_take;
	logic [2:0]       cand_start;
	token_t           close_tok;
	token_t           byte_tok;
	logic             byte_emits;
	logic [5:0]       len_out;

	assign proc     = v_s1 && (count_q <= 3'd2);
	assign s_tready = !v_s1 || proc;
	assign pop      = m_tvalid && m_tready;

	always_comb begin
		// extend the open run by one character
		cand_take = cand_q;
		for (int i = 0; i < NUM_KW; i++) begin
			if (len_q < LEN_W'(KW_LEN[i]) && KW_TEXT[i][len_q[2:0]] != byte_s1) begin
				cand_take[i] = 1'b0;
			end
			cand_start[i] = (KW_TEXT[i][0] == byte_s1);
		end
		if (len_q < LEN_SAT) begin
			len_take = len_q + 1'b1;
			ovf_take = ovf_q;
		end else begin
			len_take = len_q;
			ovf_take = 1'b1;
		end

		len_out = (len_q > LEN_W'(63)) ? 6'd63 : 6'(len_q);

		close_tok          = '0;
		close_tok.kind     = KIND_NUMBER;
		close_tok.length   = len_out;
		close_tok.too_long = ovf_q;
		if (mode_q == MODE_WORD) begin
			close_tok.kind = KIND_IDENT;
			for (int i = 0; i < NUM_KW; i++) begin
				if (!ovf_q && cand_q[i] && len_q == LEN_W'(KW_LEN[i])) begin
					close_tok.kind = KIND_KEYWORD;
				end
			end
		end

		byte_tok        = '0;
		byte_tok.kind   = KIND_SYMBOL;
		byte_tok.length = 6'd1;
		byte_tok.sym    = byte_s1;
		byte_emits      = 1'b0;

		mode_d = mode_q;
		len_d  = len_q;
		cand_d = cand_q;
		ovf_d  = ovf_q;
		res0   = close_tok;
		res1   = byte_tok;
		n_res  = 2'd0;

		if (eoi_s1) begin
			byte_tok      = '0;
			byte_tok.kind = KIND_END;
			byte_emits    = 1'b1;
			mode_d        = MODE_IDLE;
			len_d         = '0;
			cand_d        = ALL_CANDIDATES;
			ovf_d         = 1'b0;
		end else if ((mode_q == MODE_WORD && (is_word_start(byte_s1) || is_digit(byte_s1))) ||
		             (mode_q == MODE_NUM && is_digit(byte_s1))) begin
			len_d  = len_take;
			cand_d = cand_take;
			ovf_d  = ovf_take;
		end else begin
			// close any open run, then handle the byte itself
			mode_d = MODE_IDLE;
			len_d  = '0;
			cand_d = ALL_CANDIDATES;
			ovf_d  = 1'b0;
			if (is_word_start(byte_s1)) begin
				mode_d = MODE_WORD;
				len_d  = LEN_W'(1);
				cand_d = cand_start;
			end else if (is_digit(byte_s1)) begin
				mode_d = MODE_NUM;
				len_d  = LEN_W'(1);
				cand_d = cand_start;
			end else if (!is_blank(byte_s1)) begin
				byte_emits = 1'b1;
			end
		end

		if (mode_q != MODE_IDLE && (eoi_s1 || mode_d != mode_q || len_d == LEN_W'(1) ||
		    byte_emits || (len_d == '0))) begin
			// an open run was closed when it did not simply take the character
			if (!(!eoi_s1 && ((mode_q == MODE_WORD &&
			      (is_word_start(byte_s1) || is_digit(byte_s1))) ||
			      (mode_q == MODE_NUM && is_digit(byte_s1))))) begin
				res0  = close_tok;
				res1  = byte_tok;
				n_res = byte_emits ? 2'd2 : 2'd1;
			end else begin
				n_res = 2'd0;
			end
		end else if (mode_q == MODE_IDLE && byte_emits) begin
			res0  = byte_tok;
			n_res = 2'd1;
		end

		if (n_res == 2'd1) begin
			res0.last = 1'b1;
		end else if (n_res == 2'd2) begin
			res1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			cand_q <= ALL_CANDIDATES;
			ovf_q  <= 1'b0;
		end else if (proc) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			cand_q <= cand_d;
			ovf_q  <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (proc && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (proc ? 3'(n_res) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	assign m_tvalid = (count_q != 3'd0);
	assign m_tuser  = fifo_q[rd_ptr_q].kind;
	assign m_tlast  = fifo_q[rd_ptr_q].last;
	assign m_tdata  = {1'b0, fifo_q[rd_ptr_q].too_long, fifo_q[rd_ptr_q].sym,
	                   fifo_q[rd_ptr_q].length};

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("output queue overfilled");

	a_room_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && s_tready) |-> (count_q <= 3'd2))
		else $error("request taken without room for two tokens");

	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && eoi_s1) |=> (mode_q == MODE_IDLE && len_q == '0 && !ovf_q))
		else $error("lexer state not cleared after end of input");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_END) |-> (m_tlast && m_tdata == '0))
		else $error("end token malformed");

endmodule
